// ===== rtl/task_scheduler_with_sleep_queue_top_macros.svh =====
// Assertion macros shared by the scheduler RTL.
// Expects signals clk and arst_n in the including module.
`ifndef TASK_SCHEDULER_WITH_SLEEP_QUEUE_TOP_MACROS_SVH
`define TASK_SCHEDULER_WITH_SLEEP_QUEUE_TOP_MACROS_SVH

// same-cycle implication
`define TSQ_AST_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TSQ_AST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/tsq_pkg.sv =====
// Package of the task scheduler: field widths, codes, slot row and the
// controller/datapath command and status structs. No dependencies.
package tsq_pkg;

	localparam int TASK_SLOTS_DEF = 64;

	localparam int OP_W = 3;
	localparam int SLOT_W = 6;
	localparam int PRIO_W = 8;
	localparam int MS_W = 32;
	localparam int TICK_W = 32;
	localparam int TLEN_W = 10;
	localparam int STATE_W = 3;
	localparam int WOKEN_W = 7;
	localparam int STAT_W = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 10;

	localparam logic [OP_W-1:0] OP_CREATE = 3'd0;
	localparam logic [OP_W-1:0] OP_SCHED = 3'd1;
	localparam logic [OP_W-1:0] OP_BLOCK = 3'd2;
	localparam logic [OP_W-1:0] OP_UNBLOCK = 3'd3;
	localparam logic [OP_W-1:0] OP_SLEEP = 3'd4;
	localparam logic [OP_W-1:0] OP_TICK = 3'd5;

	localparam logic [STATE_W-1:0] ST_FREE = 3'd0;
	localparam logic [STATE_W-1:0] ST_READY = 3'd1;
	localparam logic [STATE_W-1:0] ST_RUNNING = 3'd2;
	localparam logic [STATE_W-1:0] ST_BLOCKED = 3'd3;
	localparam logic [STATE_W-1:0] ST_SLEEPING = 3'd4;
	localparam logic [STATE_W-1:0] ST_WAITING = 3'd5;

	localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NOFREE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_ILLEGAL = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_TICK_LEN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE = 1'd1;
	localparam logic [TLEN_W-1:0] TICK_LEN_RESET = 10'd10;
	localparam logic [SLOT_W-1:0] IDLE_RESET = 6'd0;

	localparam logic [2:0] WR_NONE = 3'd0;
	localparam logic [2:0] WR_CREATE = 3'd1;
	localparam logic [2:0] WR_CUR = 3'd2;
	localparam logic [2:0] WR_PICK = 3'd3;
	localparam logic [2:0] WR_BLOCK = 3'd4;
	localparam logic [2:0] WR_UNBLOCK = 3'd5;
	localparam logic [2:0] WR_SLEEP = 3'd6;

	localparam logic [1:0] RD_CNT = 2'd0;
	localparam logic [1:0] RD_CUR = 2'd1;
	localparam logic [1:0] RD_PICK = 2'd2;
	localparam logic [1:0] RD_SLOT = 2'd3;

	typedef struct packed {
		logic [STATE_W-1:0] state;
		logic [TICK_W-1:0] ticks;
		logic [PRIO_W-1:0] prio;
	} tsq_row_t;

	typedef struct packed {
		logic load;
		logic scan_clr;
		logic scan_rd;
		logic rd_en;
		logic [1:0] rd_sel;
		logic time_inc;
		logic div_start;
		logic [2:0] wr_kind;
		logic st_set;
		logic [STAT_W-1:0] st_code;
		logic res_load;
	} tsq_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic scan_last;
		logic slot_ok;
		logic cur_ok;
		logic [STATE_W-1:0] row_state;
		logic slot_is_cur;
		logic found;
		logic div_done;
		logic out_busy;
	} tsq_stat_t;

endpackage

// ===== rtl/tsq_req_if.sv =====
// Request channel of the scheduler: one operation per transaction.
// Depends on tsq_pkg.
interface tsq_req_if import tsq_pkg::*; ();
	logic valid;
	logic ready;
	logic [OP_W-1:0] op;
	logic [SLOT_W-1:0] slot;
	logic [PRIO_W-1:0] task_priority;
	logic block_kind;
	logic [MS_W-1:0] sleep_ms;

	modport source(output valid, op, slot, task_priority, block_kind, sleep_ms, input ready);
	modport sink(input valid, op, slot, task_priority, block_kind, sleep_ms, output ready);
endinterface

// ===== rtl/tsq_rsp_if.sv =====
// Response channel of the scheduler: one result per transaction.
// Depends on tsq_pkg.
interface tsq_rsp_if import tsq_pkg::*; ();
	logic valid;
	logic ready;
	logic [SLOT_W-1:0] next_slot;
	logic do_switch;
	logic [SLOT_W-1:0] created_slot;
	logic [WOKEN_W-1:0] woken_count;
	logic [STAT_W-1:0] status;

	modport source(output valid, next_slot, do_switch, created_slot, woken_count, status,
		input ready);
	modport sink(input valid, next_slot, do_switch, created_slot, woken_count, status,
		output ready);
endinterface

// ===== rtl/tsq_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on tsq_pkg; a zero divisor divides as one.
module tsq_div import tsq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [MS_W-1:0] dividend,
	input logic [TLEN_W-1:0] divisor,
	output logic done,
	output logic [MS_W-1:0] quotient
);
	logic busy_q, done_q;
	logic [4:0] cnt_q;
	logic [TLEN_W-1:0] rem_q, dvs_q;
	logic [MS_W-1:0] quo_q;
	logic [TLEN_W:0] trial;
	logic take;

	assign trial = {rem_q, quo_q[MS_W-1]};
	assign take = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= 5'd31;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= (divisor == '0) ? TLEN_W'(1) : divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[MS_W-2:0], take};
			rem_q <= take ? TLEN_W'(trial - {1'b0, dvs_q}) : trial[TLEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
endmodule

// ===== rtl/tsq_dp.sv =====
// Scheduler datapath: slot table memory, scan registers, time, config,
// divider and result register. Depends on tsq_pkg, tsq_rsp_if, tsq_div and the assertion macros header.
module tsq_dp import tsq_pkg::*; #(
	parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	input logic [OP_W-1:0] op,
	input logic [SLOT_W-1:0] slot,
	input logic [PRIO_W-1:0] task_priority,
	input logic block_kind,
	input logic [MS_W-1:0] sleep_ms,
	input tsq_cmd_t c,
	output tsq_stat_t s,
	tsq_rsp_if.source rsp
);
	`include "task_scheduler_with_sleep_queue_top_macros.svh"

	localparam int AW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	typedef logic [AW-1:0] addr_t;

	tsq_row_t mem [TASK_SLOTS];
	logic [TASK_SLOTS-1:0] vld_q;

	logic [OP_W-1:0] op_q;
	logic [SLOT_W-1:0] slot_q, cur0_q, current_q, idle_q, cr_q;
	logic [PRIO_W-1:0] prio_q;
	logic kind_q;
	logic [MS_W-1:0] ms_q;
	logic [TLEN_W-1:0] tick_len_q;
	logic [TICK_W-1:0] time_q, best_ticks_q;
	addr_t cnt_q, idx_s1, best_q;
	logic scan_s1, found_q, sw_q;
	logic [8:0] woken_q;
	logic [STAT_W-1:0] st_q;
	tsq_row_t row_q, row_e, wr_row;
	logic rvld_q;
	logic out_valid_q;
	logic [SLOT_W-1:0] o_next_q, o_cr_q;
	logic o_sw_q;
	logic [WOKEN_W-1:0] o_woken_q;
	logic [STAT_W-1:0] o_st_q;

	logic wr_en;
	addr_t wr_addr, rd_addr;
	logic [8:0] pick_full;
	logic ev_free, ev_sched, ev_wake;
	logic div_done;
	logic [MS_W-1:0] quo;
	logic [TICK_W-1:0] wake_t;

	function automatic logic in_rng(input logic [8:0] v);
		return v < 9'(TASK_SLOTS);
	endfunction

	tsq_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(c.div_start),
		.dividend(ms_q),
		.divisor(tick_len_q),
		.done(div_done),
		.quotient(quo)
	);

	assign row_e = rvld_q ? row_q : '0;
	assign pick_full = found_q ? 9'(best_q) : 9'(idle_q);
	assign wake_t = (quo == '0) ? TICK_W'(1) : quo;

	assign ev_free = scan_s1 && op_q == OP_CREATE && row_e.state == ST_FREE && !found_q;
	assign ev_sched = scan_s1 && op_q != OP_CREATE && op_q != OP_TICK &&
		row_e.state == ST_READY && 9'(idx_s1) != 9'(cur0_q) &&
		(!found_q || row_e.ticks > best_ticks_q);
	assign ev_wake = scan_s1 && op_q == OP_TICK && row_e.state == ST_SLEEPING &&
		row_e.ticks <= time_q;

	always_comb begin
		case (c.rd_sel)
			RD_CNT: rd_addr = cnt_q;
			RD_CUR: rd_addr = addr_t'(cur0_q);
			RD_PICK: rd_addr = addr_t'(pick_full);
			default: rd_addr = addr_t'(slot_q);
		endcase
	end

	always_comb begin
		wr_en = 1'b0;
		wr_addr = idx_s1;
		wr_row = row_e;
		if (ev_wake) begin
			wr_en = 1'b1;
			wr_row.state = ST_READY;
			wr_row.ticks = '0;
		end
		case (c.wr_kind)
			WR_CREATE: begin
				wr_en = found_q;
				wr_addr = best_q;
				wr_row.state = ST_READY;
				wr_row.ticks = TICK_W'(prio_q);
				wr_row.prio = prio_q;
			end
			WR_CUR: begin
				wr_en = in_rng(9'(cur0_q));
				wr_addr = addr_t'(cur0_q);
				if (row_e.state == ST_RUNNING)
					wr_row.state = ST_READY;
				if (row_e.ticks == '0)
					wr_row.ticks = TICK_W'(row_e.prio);
			end
			WR_PICK: begin
				wr_en = in_rng(pick_full) && row_e.state != ST_FREE;
				wr_addr = addr_t'(pick_full);
				wr_row.state = ST_RUNNING;
			end
			WR_BLOCK: begin
				wr_en = 1'b1;
				wr_addr = addr_t'(slot_q);
				wr_row.state = kind_q ? ST_WAITING : ST_BLOCKED;
			end
			WR_UNBLOCK: begin
				wr_en = 1'b1;
				wr_addr = addr_t'(slot_q);
				wr_row.state = ST_READY;
			end
			WR_SLEEP: begin
				wr_en = 1'b1;
				wr_addr = addr_t'(cur0_q);
				wr_row.state = ST_SLEEPING;
				wr_row.ticks = time_q + wake_t;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_row;
		if (c.rd_en)
			row_q <= mem[rd_addr];
		if (c.res_load) begin
			o_next_q <= current_q;
			o_sw_q <= sw_q;
			o_cr_q <= cr_q;
			o_woken_q <= woken_q[WOKEN_W-1:0];
			o_st_q <= st_q;
		end
		if (c.load) begin
			slot_q <= slot;
			prio_q <= task_priority;
			kind_q <= block_kind;
			ms_q <= sleep_ms;
		end
		idx_s1 <= cnt_q;
		if (ev_free || ev_sched) begin
			best_q <= idx_s1;
			best_ticks_q <= row_e.ticks;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rvld_q <= 1'b0;
			op_q <= OP_CREATE;
			cur0_q <= IDLE_RESET;
			current_q <= IDLE_RESET;
			idle_q <= IDLE_RESET;
			tick_len_q <= TICK_LEN_RESET;
			time_q <= '0;
			cnt_q <= '0;
			scan_s1 <= 1'b0;
			found_q <= 1'b0;
			woken_q <= '0;
			sw_q <= 1'b0;
			cr_q <= '0;
			st_q <= STAT_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == CFG_TICK_LEN)
				tick_len_q <= cfg_data[TLEN_W-1:0];
			if (cfg_we && cfg_index == CFG_IDLE)
				idle_q <= cfg_data[SLOT_W-1:0];
			if (wr_en)
				vld_q[wr_addr] <= 1'b1;
			if (c.rd_en)
				rvld_q <= vld_q[rd_addr];
			if (c.load) begin
				op_q <= op;
				cur0_q <= current_q;
				woken_q <= '0;
				sw_q <= 1'b0;
				cr_q <= '0;
				st_q <= STAT_OK;
			end
			if (c.time_inc)
				time_q <= time_q + TICK_W'(1);
			scan_s1 <= c.scan_rd;
			if (c.scan_clr) begin
				cnt_q <= '0;
				found_q <= 1'b0;
			end else if (c.scan_rd)
				cnt_q <= cnt_q + addr_t'(1);
			if (ev_free || ev_sched)
				found_q <= 1'b1;
			if (ev_wake)
				woken_q <= woken_q + 9'd1;
			if (c.wr_kind == WR_CREATE && found_q)
				cr_q <= SLOT_W'(best_q);
			if (c.wr_kind == WR_PICK) begin
				current_q <= pick_full[SLOT_W-1:0];
				sw_q <= pick_full[SLOT_W-1:0] != cur0_q;
			end
			if (c.st_set)
				st_q <= c.st_code;
			if (c.res_load)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
		end
	end

	assign s.op = op_q;
	assign s.scan_last = cnt_q == addr_t'(TASK_SLOTS - 1);
	assign s.slot_ok = in_rng(9'(slot_q));
	assign s.cur_ok = in_rng(9'(cur0_q));
	assign s.row_state = row_e.state;
	assign s.slot_is_cur = slot_q == cur0_q;
	assign s.found = found_q;
	assign s.div_done = div_done;
	assign s.out_busy = out_valid_q && !rsp.ready;

	assign rsp.valid = out_valid_q;
	assign rsp.next_slot = o_next_q;
	assign rsp.do_switch = o_sw_q;
	assign rsp.created_slot = o_cr_q;
	assign rsp.woken_count = o_woken_q;
	assign rsp.status = o_st_q;

	`TSQ_AST_IMPL(a_no_rw_clash, wr_en && c.rd_en, wr_addr != rd_addr, "slot table read/write clash")
	`TSQ_AST_IMPL(a_sw_match, c.res_load, sw_q == (current_q != cur0_q), "switch flag mismatch")
	`TSQ_AST_IMPL(a_woken_bound, 1'b1, woken_q <= 9'(TASK_SLOTS), "woken count overflow")
endmodule

// ===== rtl/tsq_ctrl.sv =====
// Scheduler controller: sequences scans, read-modify-writes and the divider.
// Depends on tsq_pkg; drives tsq_dp through tsq_cmd_t.
module tsq_ctrl import tsq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input tsq_stat_t s,
	output tsq_cmd_t c
);
	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_DISP = 5'd1;
	localparam logic [4:0] S_SSTART = 5'd2;
	localparam logic [4:0] S_SCAN = 5'd3;
	localparam logic [4:0] S_SCEND = 5'd4;
	localparam logic [4:0] S_CRWR = 5'd5;
	localparam logic [4:0] S_RDCUR = 5'd6;
	localparam logic [4:0] S_WRCUR = 5'd7;
	localparam logic [4:0] S_RDPICK = 5'd8;
	localparam logic [4:0] S_WRPICK = 5'd9;
	localparam logic [4:0] S_BLRD = 5'd10;
	localparam logic [4:0] S_BLCHK = 5'd11;
	localparam logic [4:0] S_UBRD = 5'd12;
	localparam logic [4:0] S_UBCHK = 5'd13;
	localparam logic [4:0] S_SLRD = 5'd14;
	localparam logic [4:0] S_SLCHK = 5'd15;
	localparam logic [4:0] S_SLDIV = 5'd16;
	localparam logic [4:0] S_DONE = 5'd17;

	logic [4:0] state_q, nxt;

	always_comb begin
		c = '0;
		nxt = state_q;
		req_ready = state_q == S_IDLE;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					c.load = 1'b1;
					nxt = S_DISP;
				end
			end
			S_DISP: begin
				unique case (s.op)
					OP_CREATE: begin
						c.scan_clr = 1'b1;
						nxt = S_SCAN;
					end
					OP_SCHED: nxt = S_SSTART;
					OP_BLOCK: nxt = S_BLRD;
					OP_UNBLOCK: nxt = S_UBRD;
					OP_SLEEP: nxt = S_SLRD;
					OP_TICK: begin
						c.time_inc = 1'b1;
						c.scan_clr = 1'b1;
						nxt = S_SCAN;
					end
					default: begin
						c.st_set = 1'b1;
						c.st_code = STAT_ILLEGAL;
						nxt = S_DONE;
					end
				endcase
			end
			S_SSTART: begin
				c.scan_clr = 1'b1;
				nxt = S_SCAN;
			end
			S_SCAN: begin
				c.scan_rd = 1'b1;
				c.rd_en = 1'b1;
				c.rd_sel = RD_CNT;
				if (s.scan_last)
					nxt = S_SCEND;
			end
			S_SCEND: begin
				if (s.op == OP_CREATE)
					nxt = S_CRWR;
				else if (s.op == OP_TICK)
					nxt = S_DONE;
				else
					nxt = S_RDCUR;
			end
			S_CRWR: begin
				c.wr_kind = WR_CREATE;
				if (!s.found) begin
					c.st_set = 1'b1;
					c.st_code = STAT_NOFREE;
				end
				nxt = S_DONE;
			end
			S_RDCUR: begin
				c.rd_en = 1'b1;
				c.rd_sel = RD_CUR;
				nxt = S_WRCUR;
			end
			S_WRCUR: begin
				c.wr_kind = WR_CUR;
				nxt = S_RDPICK;
			end
			S_RDPICK: begin
				c.rd_en = 1'b1;
				c.rd_sel = RD_PICK;
				nxt = S_WRPICK;
			end
			S_WRPICK: begin
				c.wr_kind = WR_PICK;
				nxt = S_DONE;
			end
			S_BLRD, S_UBRD: begin
				if (s.slot_ok) begin
					c.rd_en = 1'b1;
					c.rd_sel = RD_SLOT;
					nxt = (state_q == S_BLRD) ? S_BLCHK : S_UBCHK;
				end else begin
					c.st_set = 1'b1;
					c.st_code = STAT_ILLEGAL;
					nxt = S_DONE;
				end
			end
			S_BLCHK: begin
				if (s.row_state == ST_READY || s.row_state == ST_RUNNING) begin
					c.wr_kind = WR_BLOCK;
					nxt = s.slot_is_cur ? S_SSTART : S_DONE;
				end else begin
					c.st_set = 1'b1;
					c.st_code = STAT_ILLEGAL;
					nxt = S_DONE;
				end
			end
			S_UBCHK: begin
				if (s.row_state == ST_BLOCKED || s.row_state == ST_SLEEPING ||
					s.row_state == ST_WAITING) begin
					c.wr_kind = WR_UNBLOCK;
				end else begin
					c.st_set = 1'b1;
					c.st_code = STAT_ILLEGAL;
				end
				nxt = S_DONE;
			end
			S_SLRD: begin
				if (s.cur_ok) begin
					c.rd_en = 1'b1;
					c.rd_sel = RD_CUR;
					c.div_start = 1'b1;
					nxt = S_SLCHK;
				end else begin
					c.st_set = 1'b1;
					c.st_code = STAT_ILLEGAL;
					nxt = S_DONE;
				end
			end
			S_SLCHK: begin
				if (s.row_state == ST_READY || s.row_state == ST_RUNNING)
					nxt = S_SLDIV;
				else begin
					c.st_set = 1'b1;
					c.st_code = STAT_ILLEGAL;
					nxt = S_DONE;
				end
			end
			S_SLDIV: begin
				if (s.div_done) begin
					c.wr_kind = WR_SLEEP;
					nxt = S_SSTART;
				end
			end
			S_DONE: begin
				if (!s.out_busy) begin
					c.res_load = 1'b1;
					nxt = S_IDLE;
				end
			end
			default: nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= nxt;
	end
endmodule

// ===== rtl/task_scheduler_with_sleep_queue_top.sv =====
// Top level of the task scheduler with sleep queue.
// Depends on tsq_pkg, tsq_req_if, tsq_rsp_if, tsq_ctrl, tsq_dp.
//
// Usage: each req transaction carries one operation (create, schedule,
// block, unblock, sleep current, tick); exactly one rsp transaction
// answers it, in order. req is taken only when no operation is in flight;
// a result may still wait on rsp while the next request is accepted.
// Create and tick scan the table, one slot table read per cycle; schedule
// scans it, then updates the current and picked rows; block of the current
// task adds a schedule; sleep runs the bit-serial divider, then a schedule.
// One op at a time. cfg_we writes tick_length_ms (index 0) or idle_slot
// (index 1); the user must write only while idle, not enforced by the
// block. Reset clears the slot table valid bits, so every slot reads free;
// time, current slot and config return to their defaults. When rsp stalls,
// the block holds its finished result and waits before loading the next.
module task_scheduler_with_sleep_queue_top import tsq_pkg::*; #(
	parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	tsq_req_if.sink req,
	tsq_rsp_if.source rsp
);
	tsq_cmd_t cmd_w;
	tsq_stat_t stat_w;
	logic req_ready;

	assign req.ready = req_ready;

	tsq_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req.valid),
		.req_ready(req_ready),
		.s(stat_w),
		.c(cmd_w)
	);

	tsq_dp #(.TASK_SLOTS(TASK_SLOTS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.op(req.op),
		.slot(req.slot),
		.task_priority(req.task_priority),
		.block_kind(req.block_kind),
		.sleep_ms(req.sleep_ms),
		.c(cmd_w),
		.s(stat_w),
		.rsp(rsp)
	);
endmodule

// ===== sim/task_scheduler_with_sleep_queue_top_tb.sv =====
// Testbench of the task scheduler with sleep queue: directed and random operations
// are checked against a slot table model kept here, with random idling on both sides.
// Depends on tsq_pkg, tsq_req_if, tsq_rsp_if and task_scheduler_with_sleep_queue_top.
module task_scheduler_with_sleep_queue_top_tb;
	import tsq_pkg::*;

	localparam logic [OP_W-1:0] OP_BAD_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_BAD_HI = 3'd7;
	localparam int SETTLE_CYCLES = 200;
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [SLOT_W-1:0] next_slot;
		logic do_switch;
		logic [SLOT_W-1:0] created_slot;
		logic [WOKEN_W-1:0] woken_count;
		logic [STAT_W-1:0] status;
	} sched_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	tsq_req_if req();
	tsq_rsp_if rsp();

	task_scheduler_with_sleep_queue_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req(req.sink),
		.rsp(rsp.source)
	);

	// scheduler model state
	logic [STATE_W-1:0] task_state [TASK_SLOTS_DEF];
	logic [TICK_W-1:0] task_ticks [TASK_SLOTS_DEF];
	logic [PRIO_W-1:0] task_prio [TASK_SLOTS_DEF];
	logic [SLOT_W-1:0] cur_task;
	logic [TICK_W-1:0] now_ticks;
	logic [TLEN_W-1:0] tick_len;
	logic [SLOT_W-1:0] fallback_slot;
	int tasks_made;

	sched_result_t pending_results[$];
	bit failed;
	int burst_left;
	int hold_cnt;
	int quiet_cycles;
	int cyc;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic pick_next_task();
		logic [SLOT_W-1:0] prev;
		int pick;
		bit found;
		prev = cur_task;
		pick = 0;
		found = 0;
		for (int i = 0; i < TASK_SLOTS_DEF; i++) begin
			if (task_state[i] == ST_READY && i != prev) begin
				if (!found || task_ticks[i] > task_ticks[pick]) begin
					pick = i;
					found = 1;
				end
			end
		end
		if (!found)
			pick = fallback_slot;
		if (task_state[prev] == ST_RUNNING)
			task_state[prev] = ST_READY;
		if (task_ticks[prev] == '0)
			task_ticks[prev] = TICK_W'(task_prio[prev]);
		if (task_state[pick] != ST_FREE)
			task_state[pick] = ST_RUNNING;
		cur_task = SLOT_W'(pick);
		return cur_task != prev;
	endfunction

	function automatic sched_result_t apply_op(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
			logic [PRIO_W-1:0] prio, logic kind, logic [MS_W-1:0] ms);
		sched_result_t r;
		logic [TICK_W-1:0] span;
		r = '0;
		case (op)
			OP_CREATE: begin
				r.status = STAT_NOFREE;
				for (int i = 0; i < TASK_SLOTS_DEF; i++) begin
					if (r.status == STAT_NOFREE && task_state[i] == ST_FREE) begin
						task_state[i] = ST_READY;
						task_prio[i] = prio;
						task_ticks[i] = TICK_W'(prio);
						r.created_slot = SLOT_W'(i);
						r.status = STAT_OK;
					end
				end
			end
			OP_SCHED: r.do_switch = pick_next_task();
			OP_BLOCK: begin
				if (task_state[slot] != ST_READY && task_state[slot] != ST_RUNNING) begin
					r.status = STAT_ILLEGAL;
				end else begin
					task_state[slot] = kind ? ST_WAITING : ST_BLOCKED;
					if (slot == cur_task)
						r.do_switch = pick_next_task();
				end
			end
			OP_UNBLOCK: begin
				if (task_state[slot] != ST_BLOCKED && task_state[slot] != ST_SLEEPING &&
						task_state[slot] != ST_WAITING)
					r.status = STAT_ILLEGAL;
				else
					task_state[slot] = ST_READY;
			end
			OP_SLEEP: begin
				if (task_state[cur_task] != ST_READY && task_state[cur_task] != ST_RUNNING) begin
					r.status = STAT_ILLEGAL;
				end else begin
					span = ms / ((tick_len == '0) ? 32'd1 : 32'(tick_len));
					if (span == '0)
						span = 1;
					task_ticks[cur_task] = now_ticks + span;
					task_state[cur_task] = ST_SLEEPING;
					r.do_switch = pick_next_task();
				end
			end
			OP_TICK: begin
				now_ticks = now_ticks + 1;
				for (int i = 0; i < TASK_SLOTS_DEF; i++) begin
					if (task_state[i] == ST_SLEEPING && task_ticks[i] <= now_ticks) begin
						task_state[i] = ST_READY;
						task_ticks[i] = '0;
						r.woken_count++;
					end
				end
			end
			default: r.status = STAT_ILLEGAL;
		endcase
		r.next_slot = cur_task;
		return r;
	endfunction

	task automatic send_op(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
			logic [PRIO_W-1:0] prio, logic kind, logic [MS_W-1:0] ms);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				req.valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		@(negedge clk);
		req.valid = 1'b1;
		req.op = op;
		req.slot = slot;
		req.task_priority = prio;
		req.block_kind = kind;
		req.sleep_ms = ms;
		do @(posedge clk); while (!req.ready);
		if (op == OP_CREATE && tasks_made < TASK_SLOTS_DEF)
			tasks_made++;
		pending_results.push_back(apply_op(op, slot, prio, kind, ms));
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		req.valid = 1'b0;
		wait (pending_results.size() == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == CFG_TICK_LEN)
			tick_len = TLEN_W'(val);
		else
			fallback_slot = SLOT_W'(val);
	endtask

	// checks each response transaction against the oldest expectation
	always @(posedge clk) begin
		sched_result_t exp_r;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_results.size() == 0) begin
				$error("response with nothing expected");
				failed = 1;
			end else begin
				exp_r = pending_results.pop_front();
				if (rsp.next_slot !== exp_r.next_slot) begin
					$error("next_slot exp %0d got %0d", exp_r.next_slot, rsp.next_slot);
					failed = 1;
				end
				if (rsp.do_switch !== exp_r.do_switch) begin
					$error("do_switch exp %0d got %0d", exp_r.do_switch, rsp.do_switch);
					failed = 1;
				end
				if (rsp.created_slot !== exp_r.created_slot) begin
					$error("created_slot exp %0d got %0d", exp_r.created_slot,
						rsp.created_slot);
					failed = 1;
				end
				if (rsp.woken_count !== exp_r.woken_count) begin
					$error("woken_count exp %0d got %0d", exp_r.woken_count,
						rsp.woken_count);
					failed = 1;
				end
				if (rsp.status !== exp_r.status) begin
					$error("status exp %0d got %0d", exp_r.status, rsp.status);
					failed = 1;
				end
			end
		end
	end

	// receiver: long hold-off on request, else alternating free-run and random stalls
	always @(negedge clk) begin
		cyc++;
		if (hold_cnt > 0) begin
			hold_cnt--;
			rsp.ready = 1'b0;
		end else if ((cyc / 97) % 3 == 0) begin
			rsp.ready = 1'b1;
		end else begin
			rsp.ready = ($urandom_range(0, 9) < 6);
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic test_directed();
		send_op(OP_BAD_LO, 6'd0, 8'd1, 1'b0, 32'd0);
		send_op(OP_BAD_HI, 6'd63, 8'd255, 1'b1, 32'hFFFF_FFFF);
		send_op(OP_SCHED, 6'd0, 8'd1, 1'b0, 32'd0);
		send_op(OP_SLEEP, 6'd0, 8'd1, 1'b0, 32'd50);
		send_op(OP_BLOCK, 6'd63, 8'd1, 1'b0, 32'd0);
		send_op(OP_UNBLOCK, 6'd0, 8'd1, 1'b0, 32'd0);
		send_op(OP_CREATE, 6'd0, 8'd255, 1'b0, 32'd0);
		send_op(OP_CREATE, 6'd0, 8'd1, 1'b0, 32'd0);
		send_op(OP_CREATE, 6'd0, 8'd128, 1'b0, 32'd0);
		send_op(OP_SCHED, 6'd0, 8'd1, 1'b0, 32'd0);
		send_op(OP_BLOCK, cur_task, 8'd1, 1'b0, 32'd0);
		send_op(OP_BLOCK, 6'd1, 8'd1, 1'b1, 32'd0);
		send_op(OP_BLOCK, 6'd1, 8'd1, 1'b0, 32'd0);
		send_op(OP_UNBLOCK, 6'd1, 8'd1, 1'b0, 32'd0);
		send_op(OP_UNBLOCK, 6'd1, 8'd1, 1'b0, 32'd0);
		send_op(OP_SCHED, 6'd0, 8'd1, 1'b0, 32'd0);
		send_op(OP_SLEEP, 6'd0, 8'd1, 1'b0, 32'd0);
		send_op(OP_SLEEP, 6'd0, 8'd1, 1'b0, 32'hFFFF_FFFF);
		send_op(OP_TICK, 6'd0, 8'd1, 1'b0, 32'd0);
		send_op(OP_TICK, 6'd0, 8'd1, 1'b0, 32'd0);
		send_op(OP_UNBLOCK, 6'd0, 8'd1, 1'b0, 32'd0);
		send_op(OP_SCHED, 6'd0, 8'd1, 1'b0, 32'd0);
		send_op(OP_SCHED, 6'd0, 8'd1, 1'b0, 32'd0);
	endtask

	task automatic test_tick_length();
		write_reg(CFG_TICK_LEN, 10'd0);
		send_op(OP_SCHED, 6'd0, 8'd1, 1'b0, 32'd0);
		send_op(OP_SLEEP, 6'd0, 8'd1, 1'b0, 32'd2);
		send_op(OP_TICK, 6'd0, 8'd1, 1'b0, 32'd0);
		send_op(OP_TICK, 6'd0, 8'd1, 1'b0, 32'd0);
		write_reg(CFG_TICK_LEN, 10'd1000);
		send_op(OP_SCHED, 6'd0, 8'd1, 1'b0, 32'd0);
		send_op(OP_SLEEP, 6'd0, 8'd1, 1'b0, 32'd999);
		send_op(OP_TICK, 6'd0, 8'd1, 1'b0, 32'd0);
		send_op(OP_SLEEP, 6'd0, 8'd1, 1'b0, 32'd2500);
		repeat (3) send_op(OP_TICK, 6'd0, 8'd1, 1'b0, 32'd0);
	endtask

	task automatic test_idle_slot();
		write_reg(CFG_IDLE, 10'd63);
		for (int i = 0; i < 4; i++)
			send_op(OP_BLOCK, SLOT_W'(i), 8'd1, 1'(i), 32'd0);
		send_op(OP_SCHED, 6'd0, 8'd1, 1'b0, 32'd0);
		send_op(OP_SCHED, 6'd0, 8'd1, 1'b0, 32'd0);
		for (int i = 0; i < 4; i++)
			send_op(OP_UNBLOCK, SLOT_W'(i), 8'd1, 1'b0, 32'd0);
		send_op(OP_SCHED, 6'd0, 8'd1, 1'b0, 32'd0);
	endtask

	task automatic test_random(int n, bit with_hold);
		int sel;
		int top_slot;
		logic [OP_W-1:0] op;
		logic [SLOT_W-1:0] slot;
		logic [MS_W-1:0] ms;
		for (int k = 0; k < n; k++) begin
			if (with_hold && k == n / 3)
				hold_cnt = HOLD_CYCLES;
			sel = $urandom_range(0, 99);
			if (sel < 6)
				op = OP_CREATE;
			else if (sel < 30)
				op = OP_SCHED;
			else if (sel < 42)
				op = OP_BLOCK;
			else if (sel < 54)
				op = OP_UNBLOCK;
			else if (sel < 70)
				op = OP_SLEEP;
			else if (sel < 98)
				op = OP_TICK;
			else
				op = $urandom_range(0, 1) ? OP_BAD_HI : OP_BAD_LO;
			top_slot = (tasks_made + 1 > 63) ? 63 : tasks_made + 1;
			if ($urandom_range(0, 7) == 0)
				slot = SLOT_W'($urandom_range(0, 63));
			else if (op == OP_BLOCK && $urandom_range(0, 1))
				slot = cur_task;
			else
				slot = SLOT_W'($urandom_range(0, top_slot));
			if ($urandom_range(0, 9) == 0)
				ms = $urandom;
			else
				ms = $urandom_range(0, 8 * ((tick_len == '0) ? 1 : int'(tick_len)));
			send_op(op, slot, PRIO_W'($urandom_range(1, 255)), 1'($urandom_range(0, 1)), ms);
		end
	endtask

	task automatic test_table_full();
		repeat (TASK_SLOTS_DEF + 2)
			send_op(OP_CREATE, 6'd0, PRIO_W'($urandom_range(1, 255)), 1'b0, 32'd0);
		send_op(OP_SCHED, 6'd0, 8'd1, 1'b0, 32'd0);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req.valid = 1'b0;
		req.op = OP_SCHED;
		req.slot = '0;
		req.task_priority = '0;
		req.block_kind = 1'b0;
		req.sleep_ms = '0;
		rsp.ready = 1'b0;
		failed = 0;
		burst_left = 0;
		hold_cnt = 0;
		quiet_cycles = 0;
		cyc = 0;
		tasks_made = 0;
		for (int i = 0; i < TASK_SLOTS_DEF; i++) begin
			task_state[i] = ST_FREE;
			task_ticks[i] = '0;
			task_prio[i] = '0;
		end
		cur_task = IDLE_RESET;
		fallback_slot = IDLE_RESET;
		tick_len = TICK_LEN_RESET;
		now_ticks = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_tick_length();
		test_idle_slot();
		write_reg(CFG_TICK_LEN, 10'd1);
		test_random(150, 0);
		write_reg(CFG_TICK_LEN, 10'd1000);
		write_reg(CFG_IDLE, 10'd5);
		test_random(150, 1);
		write_reg(CFG_TICK_LEN, CFG_DATA_W'($urandom_range(0, 1023)));
		write_reg(CFG_IDLE, CFG_DATA_W'($urandom_range(0, 63)));
		test_random(150, 0);
		write_reg(CFG_TICK_LEN, 10'd10);
		write_reg(CFG_IDLE, 10'd0);
		test_random(150, 0);
		test_table_full();

		@(negedge clk);
		req.valid = 1'b0;
		wait (pending_results.size() == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (!failed && pending_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
